@@ src/i2ra_pkg.sv @@
`timescale 1ns / 1ps

package i2ra_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int IDX_W       = 5;
  localparam int COUNT_W     = 6;
  localparam int STEP_BITS   = 8;

  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_LOWER = 7'h61;
  localparam logic [6:0] CHAR_UPPER = 7'h41;

  typedef struct packed {
    logic load;
    logic step;
    logic last_pass;
    logic show_sign;
    logic show_digit;
    logic rd_dec;
  } i2ra_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic neg;
    logic out_taken;
    logic last_digit;
  } i2ra_stat_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic lower);
    logic [6:0] ch;
    if (d < 4'd10) begin
      ch = CHAR_ZERO + {3'b000, d};
    end else begin
      ch = (lower ? CHAR_LOWER : CHAR_UPPER) + {3'b000, d} - 7'd10;
    end
    return ch;
  endfunction

endpackage

@@ src/i2ra_dp.sv @@
`timescale 1ns / 1ps

module i2ra_dp import i2ra_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  i2ra_cmd_t   cmd,
  output i2ra_stat_t  stat,
  input  logic [31:0] number,
  input  logic [4:0]  base,
  input  logic        unsigned_mode,
  input  logic        lowercase,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  character,
  output logic        last
);

  localparam int EW     = (WIDTH < 32) ? WIDTH : 32;
  localparam int PASSES = (EW + STEP_BITS - 1) / STEP_BITS;
  localparam int QW     = PASSES * STEP_BITS;

  logic [QW-1:0]      quot;
  logic [QW-1:0]      quot_next;
  logic [3:0]         rem;
  logic [3:0]         rem_next;
  logic [4:0]         base_r;
  logic               lower_r;
  logic               neg;
  logic [COUNT_W-1:0] count;
  logic [IDX_W-1:0]   rd_idx;
  logic [3:0]         rd_data;
  logic [3:0]         store [STORE_DEPTH];

  logic [EW-1:0]      word_in;
  logic [EW-1:0]      mag;
  logic               neg_in;
  logic [4:0]         base_c;

  assign word_in = number[EW-1:0];
  assign neg_in  = !unsigned_mode && word_in[EW-1];
  assign mag     = neg_in ? (~word_in + 1'b1) : word_in;
  assign base_c  = (base > 5'd16) ? 5'd16 : ((base < 5'd2) ? 5'd2 : base);

  // Long division by the base, eight quotient bits per cycle. The remainder
  // stays below the base, so four bits hold it between steps.
  always_comb begin
    logic [4:0]           r;
    logic [3:0]           rv;
    logic [STEP_BITS-1:0] qb;
    logic [QW+STEP_BITS-1:0] cat;
    rv = rem;
    qb = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      r = {rv, quot[QW-1-i]};
      if (r >= base_r) begin
        r = r - base_r;
        qb[STEP_BITS-1-i] = 1'b1;
      end
      rv = r[3:0];
    end
    cat       = {quot, qb};
    quot_next = cat[QW-1:0];
    rem_next  = rv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      quot  <= '0;
      rem   <= '0;
    end else if (cmd.load) begin
      count <= '0;
      quot  <= {{(QW-EW){1'b0}}, mag};
      rem   <= '0;
    end else if (cmd.step) begin
      quot <= quot_next;
      if (cmd.last_pass) begin
        rem   <= '0;
        count <= count + 1'b1;
      end else begin
        rem <= rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r  <= base_c;
      lower_r <= lowercase;
      neg     <= neg_in;
    end
    if (cmd.step && cmd.last_pass) begin
      store[count[IDX_W-1:0]] <= rem_next;
      rd_idx <= count[IDX_W-1:0];
    end else if (cmd.rd_dec) begin
      rd_idx <= rd_idx - 1'b1;
    end
    rd_data <= store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.show_sign || cmd.show_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.show_sign) begin
      character <= CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.show_digit) begin
      character <= digit_char(rd_data, lower_r);
      last      <= (rd_idx == '0);
    end
  end

  assign stat.conv_done  = (quot_next == '0) ||
                           (count == COUNT_W'(STORE_DEPTH - 1));
  assign stat.neg        = neg;
  assign stat.out_taken  = out_valid && out_ready;
  assign stat.last_digit = (rd_idx == '0);

endmodule

@@ src/i2ra_ctrl.sv @@
`timescale 1ns / 1ps

module i2ra_ctrl import i2ra_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  i2ra_stat_t stat,
  output i2ra_cmd_t  cmd
);

  localparam int EW     = (WIDTH < 32) ? WIDTH : 32;
  localparam int PASSES = (EW + STEP_BITS - 1) / STEP_BITS;
  localparam int PW     = (PASSES > 1) ? $clog2(PASSES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_SIGN_WAIT,
    S_FETCH,
    S_SHOW,
    S_WAIT
  } state_t;

  state_t        state;
  logic [PW-1:0] pass;
  logic          last_pass;

  assign last_pass = (pass == PW'(PASSES - 1));
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.step       = (state == S_DIV);
    cmd.last_pass  = (state == S_DIV) && last_pass;
    cmd.show_sign  = (state == S_SIGN);
    cmd.show_digit = (state == S_SHOW);
    cmd.rd_dec     = (state == S_WAIT) && stat.out_taken && !stat.last_digit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          pass <= '0;
          if (in_valid) state <= S_DIV;
        end
        S_DIV: begin
          if (last_pass) begin
            pass <= '0;
            if (stat.conv_done) state <= stat.neg ? S_SIGN : S_FETCH;
          end else begin
            pass <= pass + 1'b1;
          end
        end
        S_SIGN:      state <= S_SIGN_WAIT;
        S_SIGN_WAIT: if (stat.out_taken) state <= S_FETCH;
        S_FETCH:     state <= S_SHOW;
        S_SHOW:      state <= S_WAIT;
        S_WAIT: begin
          if (stat.out_taken) state <= stat.last_digit ? S_IDLE : S_FETCH;
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/integer_to_radix_ascii_core.sv @@
`timescale 1ns / 1ps
// Channel | Signals                                      | Direction
// input   | in_valid, in_ready, number, base,            | into the block
//         | unsigned_mode, lowercase                     |
// output  | out_valid, out_ready, character, last        | out of the block
//
// Each digit is one full division of the min(WIDTH,32)-bit quotient by the base,
// run in passes of the shared divider, which retires eight quotient bits a
// cycle; emitting a digit goes through the registered digit store read, the
// output register load and a wait for the hand-off, and a minus sign goes first
// through its own load and wait. The longest item is the signed minimum in base two.
// Reset is synchronous; it empties the output register and idles the block.
// A stalled output holds the character in place and the block waits.

module integer_to_radix_ascii_core import i2ra_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] number,
  input  logic [4:0]  base,
  input  logic        unsigned_mode,
  input  logic        lowercase,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  character,
  output logic        last
);

  i2ra_cmd_t  cmd;
  i2ra_stat_t stat;

  i2ra_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  i2ra_dp #(.WIDTH(WIDTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .number        (number),
    .base          (base),
    .unsigned_mode (unsigned_mode),
    .lowercase     (lowercase),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .character     (character),
    .last          (last)
  );

  // The block takes no new item while a character is still on offer.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while a character is pending");

  // Delivering the final character returns the block to accepting items.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("block not idle after final character");

  // An accepted item starts a conversion, never an immediate output.
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!out_valid && !in_ready))
    else $error("output or ready right after accepting an item");

endmodule

@@ verif/integer_to_radix_ascii_core_tb.sv @@
`timescale 1ns / 1ps

module integer_to_radix_ascii_core_tb;
  import i2ra_pkg::*;

  localparam int QUIET_LIMIT   = 5000;
  localparam int ITEMS_A_PHASE = 75;
  localparam int DRAIN_CYCLES  = 300;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } ascii_char_t;

  class radix_string_scoreboard;
    ascii_char_t awaited_chars[$];
    int          mismatches;

    // Expand one accepted number into the characters it must produce.
    function void note_number(logic [31:0] num, logic [4:0] radix_in, logic uns,
                              logic lower);
      logic [31:0] mag;
      logic [4:0]  radix;
      logic [3:0]  digits[32];
      logic        neg;
      int          count;
      ascii_char_t c;
      if (radix_in > 5'd16) begin
        radix = 5'd16;
      end else if (radix_in < 5'd2) begin
        radix = 5'd2;
      end else begin
        radix = radix_in;
      end
      neg = !uns && num[31];
      mag = neg ? (~num + 32'd1) : num;
      count = 0;
      do begin
        digits[count] = 4'(mag % {27'd0, radix});
        mag = mag / {27'd0, radix};
        count++;
      end while (mag != 32'd0 && count < 32);
      if (neg) begin
        c.ch = CHAR_MINUS;
        c.last = 1'b0;
        awaited_chars.push_back(c);
      end
      for (int k = count - 1; k >= 0; k--) begin
        if (digits[k] < 4'd10) begin
          c.ch = CHAR_ZERO + 7'(digits[k]);
        end else begin
          c.ch = (lower ? CHAR_LOWER : CHAR_UPPER) + 7'(digits[k]) - 7'd10;
        end
        c.last = (k == 0);
        awaited_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [6:0] ch, logic last_flag);
      ascii_char_t want;
      if (awaited_chars.size() == 0) begin
        $display("%0t: unexpected item character=%h last=%b", $time, ch, last_flag);
        mismatches++;
      end else begin
        want = awaited_chars.pop_front();
        if (ch !== want.ch) begin
          $display("%0t: character expected %h actual %h", $time, want.ch, ch);
          mismatches++;
        end
        if (last_flag !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last_flag);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return awaited_chars.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] number = 32'd0;
  logic [4:0]  base = 5'd10;
  logic        unsigned_mode = 1'b0;
  logic        lowercase = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  character;
  logic        last;

  int src_idle = 0;
  int sink_idle = 0;
  radix_string_scoreboard sb;

  integer_to_radix_ascii_core #(.WIDTH(32)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .number(number),
    .base(base),
    .unsigned_mode(unsigned_mode),
    .lowercase(lowercase),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .character(character),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Valid is only lowered when a gap is rolled, so back-to-back items keep it high.
  task automatic send_number(input logic [31:0] n, input logic [4:0] b, input logic u,
                             input logic l);
    if ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    in_valid <= 1'b1;
    number <= n;
    base <= b;
    unsigned_mode <= u;
    lowercase <= l;
    do @(posedge clk); while (!in_ready);
    sb.note_number(n, b, u, l);
  endtask

  function automatic logic [31:0] pick_number();
    logic [31:0] n;
    case ($urandom_range(6))
      0: n = $urandom_range(0, 40);
      1: n = 32'h8000_0000 + $urandom_range(0, 8);
      2: n = 32'hFFFF_FFFF - $urandom_range(0, 8);
      3: n = 32'd1 << $urandom_range(0, 31);
      4: n = $urandom >> $urandom_range(0, 31);
      default: n = $urandom;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] pick_base();
    if ($urandom_range(9) == 0) begin
      return 5'($urandom_range(0, 31));
    end
    return 5'($urandom_range(2, 16));
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_char(character, last);
    end
    out_ready <= ($urandom_range(99) >= sink_idle);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    sb = new;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero, extremes of the word, the signed minimum, and clamped bases.
    send_number(32'd0, 5'd10, 1'b0, 1'b0);
    send_number(32'd0, 5'd2, 1'b1, 1'b1);
    send_number(32'hFFFF_FFFF, 5'd2, 1'b1, 1'b0);
    send_number(32'hFFFF_FFFF, 5'd2, 1'b0, 1'b0);
    send_number(32'hFFFF_FFFF, 5'd16, 1'b1, 1'b1);
    send_number(32'h8000_0000, 5'd2, 1'b0, 1'b0);
    send_number(32'h8000_0000, 5'd10, 1'b0, 1'b1);
    send_number(32'h8000_0000, 5'd16, 1'b1, 1'b0);
    send_number(32'h7FFF_FFFF, 5'd2, 1'b0, 1'b0);
    send_number(32'h7FFF_FFFF, 5'd10, 1'b1, 1'b0);
    send_number(32'hDEAD_BEEF, 5'd16, 1'b1, 1'b0);
    send_number(32'hDEAD_BEEF, 5'd16, 1'b1, 1'b1);
    send_number(32'hDEAD_BEEF, 5'd16, 1'b0, 1'b1);
    send_number(32'hABCD_EF01, 5'd17, 1'b1, 1'b1);
    send_number(32'hABCD_EF01, 5'd31, 1'b1, 1'b0);
    send_number(32'd5, 5'd0, 1'b1, 1'b0);
    send_number(32'hFFFF_FFFB, 5'd1, 1'b0, 1'b0);
    send_number(32'd255, 5'd3, 1'b1, 1'b0);
    send_number(32'd123456789, 5'd7, 1'b0, 1'b0);
    send_number(32'hFFFF_FF85, 5'd10, 1'b0, 1'b0);
    send_number(32'd4095, 5'd15, 1'b1, 1'b1);
    send_number(32'd15, 5'd16, 1'b0, 1'b1);
    send_number(32'd1, 5'd9, 1'b0, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle = 0;  sink_idle = 0;  end
        1: begin src_idle = 55; sink_idle = 0;  end
        2: begin src_idle = 0;  sink_idle = 55; end
        default: begin src_idle = 10; sink_idle = 10; end
      endcase
      for (int i = 0; i < ITEMS_A_PHASE; i++) begin
        send_number(pick_number(), pick_base(), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
